@@ sv/gps_pkg.sv @@
`timescale 1ns / 1ps
// Package for the greedy prime-sum splitter: microcode word, status group,
// operation and condition codes, and the microcode table. No dependencies.
package gps_pkg;

  localparam int TERM_WIDTH = 16;
  localparam int MAX_TERMS  = 8;
  localparam int COUNT_W    = 3;
  localparam int UPC_W      = 4;
  localparam int OP_W       = 4;
  localparam int COND_W     = 4;

  typedef logic [UPC_W-1:0]  upc_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [COND_W-1:0] cond_t;

  // datapath operations
  localparam op_t OP_NOP        = 4'd0;
  localparam op_t OP_LOAD       = 4'd1;
  localparam op_t OP_INIT_C     = 4'd2;
  localparam op_t OP_INIT_D     = 4'd3;
  localparam op_t OP_DIV_START  = 4'd4;
  localparam op_t OP_INC_D      = 4'd5;
  localparam op_t OP_DEC_C      = 4'd6;
  localparam op_t OP_EMIT       = 4'd7;
  localparam op_t OP_LOAD_C_SUM = 4'd8;

  // jump conditions
  localparam cond_t COND_NEVER    = 4'd0;
  localparam cond_t COND_ALWAYS   = 4'd1;
  localparam cond_t COND_NO_START = 4'd2;
  localparam cond_t COND_LT2      = 4'd3;
  localparam cond_t COND_DIRECT   = 4'd4;
  localparam cond_t COND_C_LT2    = 4'd5;
  localparam cond_t COND_GAP1     = 4'd6;
  localparam cond_t COND_SQ_GT_C  = 4'd7;
  localparam cond_t COND_DIV_BUSY = 4'd8;
  localparam cond_t COND_REM_ZERO = 4'd9;
  localparam cond_t COND_LAST     = 4'd10;

  // program addresses
  localparam upc_t UA_IDLE   = 4'd0;
  localparam upc_t UA_CHK_LT = 4'd1;
  localparam upc_t UA_CHK_DR = 4'd2;
  localparam upc_t UA_INIT_C = 4'd3;
  localparam upc_t UA_LOOP   = 4'd4;
  localparam upc_t UA_GAP    = 4'd5;
  localparam upc_t UA_INIT_D = 4'd6;
  localparam upc_t UA_TEST   = 4'd7;
  localparam upc_t UA_DIV    = 4'd8;
  localparam upc_t UA_WAIT   = 4'd9;
  localparam upc_t UA_REM    = 4'd10;
  localparam upc_t UA_INC_D  = 4'd11;
  localparam upc_t UA_NEXT_C = 4'd12;
  localparam upc_t UA_EMIT   = 4'd13;
  localparam upc_t UA_BACK   = 4'd14;
  localparam upc_t UA_DIRECT = 4'd15;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_word_t;

  typedef struct packed {
    logic lt2;
    logic direct;
    logic c_lt2;
    logic gap1;
    logic sq_gt_c;
    logic div_busy;
    logic rem_zero;
    logic last;
  } status_t;

  function automatic ctrl_word_t ucode(input upc_t addr);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, cond: COND_NEVER, target: UA_IDLE};
    case (addr)
      UA_IDLE:   cw = '{op: OP_LOAD,       cond: COND_NO_START, target: UA_IDLE};
      UA_CHK_LT: cw = '{op: OP_NOP,        cond: COND_LT2,      target: UA_IDLE};
      UA_CHK_DR: cw = '{op: OP_NOP,        cond: COND_DIRECT,   target: UA_DIRECT};
      UA_INIT_C: cw = '{op: OP_INIT_C,     cond: COND_NEVER,    target: UA_IDLE};
      UA_LOOP:   cw = '{op: OP_NOP,        cond: COND_C_LT2,    target: UA_IDLE};
      UA_GAP:    cw = '{op: OP_NOP,        cond: COND_GAP1,     target: UA_NEXT_C};
      UA_INIT_D: cw = '{op: OP_INIT_D,     cond: COND_NEVER,    target: UA_IDLE};
      UA_TEST:   cw = '{op: OP_NOP,        cond: COND_SQ_GT_C,  target: UA_EMIT};
      UA_DIV:    cw = '{op: OP_DIV_START,  cond: COND_NEVER,    target: UA_IDLE};
      UA_WAIT:   cw = '{op: OP_NOP,        cond: COND_DIV_BUSY, target: UA_WAIT};
      UA_REM:    cw = '{op: OP_NOP,        cond: COND_REM_ZERO, target: UA_NEXT_C};
      UA_INC_D:  cw = '{op: OP_INC_D,      cond: COND_ALWAYS,   target: UA_TEST};
      UA_NEXT_C: cw = '{op: OP_DEC_C,      cond: COND_ALWAYS,   target: UA_LOOP};
      UA_EMIT:   cw = '{op: OP_EMIT,       cond: COND_LAST,     target: UA_IDLE};
      UA_BACK:   cw = '{op: OP_NOP,        cond: COND_ALWAYS,   target: UA_LOOP};
      UA_DIRECT: cw = '{op: OP_LOAD_C_SUM, cond: COND_ALWAYS,   target: UA_EMIT};
      default:   cw = '{op: OP_NOP,        cond: COND_ALWAYS,   target: UA_IDLE};
    endcase
    return cw;
  endfunction

endpackage

@@ sv/greedy_prime_sum_splitter.sv @@
`timescale 1ns / 1ps
// Top level of the greedy prime-sum splitter: sequencer plus datapath.
// Depends on gps_pkg, gps_seq, gps_datapath and gps_div.
//
// A value is taken when start is high and busy is low; busy falls in the cycle
// that carries the last term. Terms come largest first, each on prime_term for one
// cycle with term_strobe, the final one with last_term; the receiver cannot
// hold them off. Inputs below 2 give no terms. Latency is data dependent: each
// candidate is tried against divisors from 2 upward until one divides it or the
// divisor's square exceeds it, each trial in the serial remainder unit, which is
// the one shared divider and sets the rate. An input below 2 keeps busy high for
// one cycle; a direct term passes the two checks and a load step, then is emitted.
// cfg_data picks the variant: 1 (reset) splits prime inputs above 3, 0 emits a
// prime input as itself. Write it only while busy is low.
module greedy_prime_sum_splitter #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [VALUE_WIDTH-1:0]         value,
  output logic                           busy,
  output logic                           term_strobe,
  output logic [gps_pkg::TERM_WIDTH-1:0] prime_term,
  output logic                           last_term,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data
);

  import gps_pkg::*;

  op_t     op;
  status_t status;

  assign cfg_ready = 1'b1;

  gps_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .op    (op),
    .busy  (busy)
  );

  gps_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .value      (value),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .status     (status),
    .term_strobe(term_strobe),
    .prime_term (prime_term),
    .last_term  (last_term)
  );

`ifndef SYNTHESIS
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    term_strobe |-> $past(busy))
    else $error("term transfer without work in progress");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (term_strobe && last_term) |-> !busy)
    else $error("still busy after last term");

  a_more_terms_busy: assert property (@(posedge clk) disable iff (rst)
    (term_strobe && !last_term) |-> busy)
    else $error("idle before last term");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted value did not start work");
`endif

endmodule

@@ sv/gps_div.sv @@
`timescale 1ns / 1ps
// Serial restoring remainder unit, one quotient bit per cycle.
// Standalone; used by gps_datapath for trial division.
module gps_div #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   busy,
  output logic [VALUE_WIDTH-1:0] remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] shift;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH:0]   partial;
  logic [VALUE_WIDTH:0]   diff;

  assign partial = {rem, shift[VALUE_WIDTH-1]};
  assign diff    = partial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(VALUE_WIDTH);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shift <= dividend;
    end else if (busy) begin
      rem   <= diff[VALUE_WIDTH] ? partial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
      shift <= {shift[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  assign busy      = (cnt != '0);
  assign remainder = rem;

endmodule

@@ sv/gps_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: remaining sum, candidate, trial divisor and its square, term count,
// variant register and result registers. Uses gps_pkg and gps_div.
module gps_datapath #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gps_pkg::op_t                   op,
  input  logic [VALUE_WIDTH-1:0]         value,
  input  logic                           cfg_valid,
  input  logic                           cfg_data,
  output gps_pkg::status_t               status,
  output logic                           term_strobe,
  output logic [gps_pkg::TERM_WIDTH-1:0] prime_term,
  output logic                           last_term
);

  import gps_pkg::*;

  logic [VALUE_WIDTH-1:0]            sum;
  logic [VALUE_WIDTH-1:0]            c;
  logic [VALUE_WIDTH-1:0]            d;
  logic [VALUE_WIDTH:0]              sq;
  logic [COUNT_W-1:0]                count;
  logic                              split;
  logic [VALUE_WIDTH-1:0]            gap;
  logic                              div_busy;
  logic [VALUE_WIDTH-1:0]            rem;
  logic [TERM_WIDTH+VALUE_WIDTH-1:0] term_wide;

  assign gap       = sum - c;
  assign term_wide = {{TERM_WIDTH{1'b0}}, c};

  gps_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (op == OP_DIV_START),
    .dividend (c),
    .divisor  (d),
    .busy     (div_busy),
    .remainder(rem)
  );

  always_comb begin
    status.lt2      = (sum < VALUE_WIDTH'(2));
    status.direct   = split && ((sum == VALUE_WIDTH'(2)) || (sum == VALUE_WIDTH'(3)));
    status.c_lt2    = (c < VALUE_WIDTH'(2));
    status.gap1     = (gap == VALUE_WIDTH'(1));
    status.sq_gt_c  = (sq > {1'b0, c});
    status.div_busy = div_busy;
    status.rem_zero = (rem == '0);
    status.last     = (gap == '0) || (count == COUNT_W'(MAX_TERMS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      split <= 1'b1;
    end else if (cfg_valid) begin
      split <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      c     <= '0;
      d     <= '0;
      sq    <= '0;
      count <= '0;
    end else begin
      case (op)
        OP_LOAD: begin
          sum <= value;
        end
        OP_INIT_C: begin
          c     <= split ? sum - 1'b1 : sum;
          count <= '0;
        end
        OP_INIT_D: begin
          d  <= VALUE_WIDTH'(2);
          sq <= (VALUE_WIDTH + 1)'(4);
        end
        OP_INC_D: begin
          d  <= d + 1'b1;
          sq <= sq + {d, 1'b1};
        end
        OP_DEC_C: begin
          c <= c - 1'b1;
        end
        OP_EMIT: begin
          sum   <= gap;
          c     <= gap;
          count <= count + 1'b1;
        end
        OP_LOAD_C_SUM: begin
          c <= sum;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_strobe <= 1'b0;
    end else begin
      term_strobe <= (op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      prime_term <= term_wide[TERM_WIDTH-1:0];
      last_term  <= status.last;
    end
  end

endmodule

@@ sv/gps_seq.sv @@
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control-word table and jump logic.
// Uses gps_pkg for the table, codes and status group.
module gps_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  gps_pkg::status_t status,
  output gps_pkg::op_t     op,
  output logic             busy
);

  import gps_pkg::*;

  upc_t       upc;
  upc_t       upc_next;
  ctrl_word_t cw;
  logic       taken;

  assign cw = ucode(upc);
  assign op = cw.op;

  always_comb begin
    case (cw.cond)
      COND_NEVER:    taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_NO_START: taken = !start;
      COND_LT2:      taken = status.lt2;
      COND_DIRECT:   taken = status.direct;
      COND_C_LT2:    taken = status.c_lt2;
      COND_GAP1:     taken = status.gap1;
      COND_SQ_GT_C:  taken = status.sq_gt_c;
      COND_DIV_BUSY: taken = status.div_busy;
      COND_REM_ZERO: taken = status.rem_zero;
      COND_LAST:     taken = status.last;
      default:       taken = 1'b1;
    endcase
  end

  assign upc_next = taken ? cw.target : upc + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  assign busy = (upc != UA_IDLE);

endmodule
